/* rtl/core/sxf_pkg.sv */
// Shared types and constants for the sprite XOR framebuffer.
// Used by sxf_ctrl, sxf_datapath and sprite_xor_framebuffer; no dependencies.
`default_nettype none

package sxf_pkg;

    // Screen geometry
    localparam int unsigned WIDTH      = 64;
    localparam int unsigned HEIGHT     = 32;
    localparam int unsigned ROW_BITS_W = 64;                 // row word, fixed by the field
    localparam int unsigned ADDR_W     = $clog2(HEIGHT);     // row address into the store
    localparam int unsigned ROWCALC_W  = 7;                  // holds y + row_index and HEIGHT

    localparam logic [ROWCALC_W-1:0] HEIGHT_LIM = ROWCALC_W'(HEIGHT);

    // Columns at WIDTH and beyond are cut off
    localparam logic [ROW_BITS_W-1:0] VIS_MASK = ~(ROW_BITS_W'(0)) << (ROW_BITS_W - WIDTH);

    // Field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned X_W      = 6;
    localparam int unsigned Y_W      = 5;
    localparam int unsigned RIDX_W   = 4;
    localparam int unsigned SPRITE_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture request, start the row read
        logic commit;   // write back, update flag, load the result
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic result_due;   // held request produces a result
        logic out_busy;     // result register still occupied
    } ctrl_stat_t;

endpackage

`default_nettype wire

/* rtl/core/sxf_ctrl.sv */
// Controller for the sprite XOR framebuffer: two-state sequencer.
// Depends on sxf_pkg for the command and status structs.
`default_nettype none

module sxf_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    m_ready,
    input  wire sxf_pkg::ctrl_stat_t stat,
    output sxf_pkg::ctrl_cmd_t     cmd
);
    import sxf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic proceed;

    // Hold in EXEC while a result is due and the result register cannot take it
    assign proceed = !stat.result_due || !stat.out_busy || m_ready;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.load   = s_ready && s_valid;
    assign cmd.commit = (state_reg == ST_EXEC) && proceed;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (proceed) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sxf_datapath.sv */
// Datapath for the sprite XOR framebuffer: row store, valid bits, XOR
// merge, collision flag and result register. Depends on sxf_pkg.
`default_nettype none

module sxf_datapath (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire sxf_pkg::ctrl_cmd_t              cmd,
    output sxf_pkg::ctrl_stat_t                  stat,
    input  wire [sxf_pkg::CMD_W-1:0]             s_command,
    input  wire [sxf_pkg::X_W-1:0]               s_x,
    input  wire [sxf_pkg::Y_W-1:0]               s_y,
    input  wire [sxf_pkg::RIDX_W-1:0]            s_row_index,
    input  wire [sxf_pkg::SPRITE_W-1:0]          s_sprite_byte,
    input  wire                                  s_last_row,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic                                 m_collision,
    output logic [sxf_pkg::ROW_BITS_W-1:0]       m_row_bits
);
    import sxf_pkg::*;

    // Row store; entries without a valid bit read as blank
    logic [ROW_BITS_W-1:0] pixel_mem [HEIGHT];
    logic [HEIGHT-1:0]     row_valid_reg;
    logic [HEIGHT-1:0]     row_valid_next;

    // Held request
    logic [CMD_W-1:0]      cmd_reg;
    logic [X_W-1:0]        x_reg;
    logic [SPRITE_W-1:0]   sprite_reg;
    logic                  last_reg;
    logic                  row_ok_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ROW_BITS_W-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    logic                  coll_seen_reg;
    logic                  coll_seen_next;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  m_collision_reg;
    logic [ROW_BITS_W-1:0] m_row_bits_reg;

    logic [ROWCALC_W-1:0]  row_full;
    logic                  in_range;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ROW_BITS_W-1:0] row_val;
    logic [ROW_BITS_W-1:0] spr_bits;
    logic [ROW_BITS_W-1:0] new_row;
    logic                  hit;
    logic                  coll_now;
    logic                  is_draw;
    logic                  is_read;

    // Target row: y + row_index for draw, y for read
    always_comb begin
        if (s_command == CMD_DRAW) begin
            row_full = ROWCALC_W'(s_y) + ROWCALC_W'(s_row_index);
        end else begin
            row_full = ROWCALC_W'(s_y);
        end
    end
    assign in_range = (row_full < HEIGHT_LIM);
    assign rd_addr  = row_full[ADDR_W-1:0];

    // Capture the request and read its row word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= s_command;
            x_reg      <= s_x;
            sprite_reg <= s_sprite_byte;
            last_reg   <= s_last_row;
            row_ok_reg <= in_range;
            addr_reg   <= rd_addr;
            if (in_range) begin
                rd_data_reg <= pixel_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            rd_valid_reg <= in_range ? row_valid_reg[rd_addr] : 1'b0;
        end
    end

    assign is_draw  = (cmd_reg == CMD_DRAW);
    assign is_read  = (cmd_reg == CMD_READ);
    assign row_val  = rd_valid_reg ? rd_data_reg : '0;
    assign spr_bits = ({sprite_reg, (ROW_BITS_W - SPRITE_W)'(0)} >> x_reg) & VIS_MASK;
    assign new_row  = row_val ^ spr_bits;
    assign hit      = row_ok_reg && ((row_val & spr_bits) != '0);
    assign coll_now = coll_seen_reg || hit;

    assign stat.result_due = (is_draw && last_reg) || is_read;
    assign stat.out_busy   = m_valid_reg;

    // Write back the merged row
    always_ff @(posedge aclk) begin
        if (cmd.commit && is_draw && row_ok_reg) begin
            pixel_mem[addr_reg] <= new_row;
        end
    end

    always_comb begin
        row_valid_next = row_valid_reg;
        coll_seen_next = coll_seen_reg;
        if (cmd.commit) begin
            case (cmd_reg)
                CMD_CLEAR: begin
                    row_valid_next = '0;
                end
                CMD_DRAW: begin
                    if (row_ok_reg) begin
                        row_valid_next[addr_reg] = 1'b1;
                    end
                    coll_seen_next = last_reg ? 1'b0 : coll_now;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.commit && stat.result_due) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            coll_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            coll_seen_reg <= coll_seen_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && stat.result_due) begin
            m_collision_reg <= is_draw ? coll_now : 1'b0;
            m_row_bits_reg  <= is_read ? row_val : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_collision = m_collision_reg;
    assign m_row_bits  = m_row_bits_reg;

endmodule

`default_nettype wire

/* rtl/core/sprite_xor_framebuffer.sv */
// Top level of the sprite XOR framebuffer.
// Depends on sxf_pkg, sxf_ctrl and sxf_datapath.
`default_nettype none

// Monochrome framebuffer of HEIGHT rows by WIDTH pixels (sxf_pkg), one bit
// per pixel, blank after reset. Each request is one of: clear, which blanks
// the whole screen at once through per-row valid bits and returns nothing;
// draw, which XORs one sprite byte into row y + row_index with bit 7 at
// column x, clipping anything past the right or bottom edge, and returns
// the sticky collision flag (then cleared) only when last_row is set; read,
// which returns row y with column 0 in bit 63, or zero for a row off screen.
// Command code 3 is ignored. A request is handled in two steps: the first captures it
// and reads its row word from the single-port row store, the second merges and
// writes the word back and loads the result register. The second step
// stretches while a result is due and the previous result has not yet been
// taken. s_ready is high whenever no request is in flight, so a new request
// is taken while an earlier result still waits on the m_ side.
module sprite_xor_framebuffer (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [sxf_pkg::CMD_W-1:0]        s_command,
    input  wire [sxf_pkg::X_W-1:0]          s_x,
    input  wire [sxf_pkg::Y_W-1:0]          s_y,
    input  wire [sxf_pkg::RIDX_W-1:0]       s_row_index,
    input  wire [sxf_pkg::SPRITE_W-1:0]     s_sprite_byte,
    input  wire                             s_last_row,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_collision,
    output logic [sxf_pkg::ROW_BITS_W-1:0]  m_row_bits
);
    import sxf_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Sequence each request: capture, then commit
    sxf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the screen, merge sprites and drive the result
    sxf_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_command     (s_command),
        .s_x           (s_x),
        .s_y           (s_y),
        .s_row_index   (s_row_index),
        .s_sprite_byte (s_sprite_byte),
        .s_last_row    (s_last_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_collision   (m_collision),
        .m_row_bits    (m_row_bits)
    );

endmodule

`default_nettype wire

/* verif/tb_sprite_xor_framebuffer.sv */
// Self-checking testbench for sprite_xor_framebuffer: clear, draw and read requests.
// Holds its own copy of the screen and collision flag to predict every result.
// Depends on sxf_pkg and the sprite_xor_framebuffer RTL only.
module tb_sprite_xor_framebuffer;
    timeunit 1ns;
    timeprecision 1ps;

    import sxf_pkg::*;

    // Command 3 has no meaning in the block; the stimulus sends it as noise
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Columns that exist on screen, column 0 at the top bit
    localparam logic [ROW_BITS_W-1:0] ON_SCREEN = ~(ROW_BITS_W'(0)) << (ROW_BITS_W - WIDTH);

    localparam int RANDOM_REQUESTS = 1100;
    localparam int CYCLE_LIMIT     = 500_000;
    localparam int SETTLE_CYCLES   = 10;

    // One request on the s_ side, plus a flag that makes the sender hold
    // until every outstanding result has been delivered
    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [X_W-1:0]      x;
        logic [Y_W-1:0]      y;
        logic [RIDX_W-1:0]   row_index;
        logic [SPRITE_W-1:0] sprite_byte;
        logic                last_row;
        bit                  drain_first;
    } fb_request_t;

    typedef struct {
        logic                  collision;
        logic [ROW_BITS_W-1:0] row_bits;
    } fb_result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_ROTATE,
        READY_SPARSE,
        READY_LONG
    } ready_style_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command;
    logic [X_W-1:0]        s_x;
    logic [Y_W-1:0]        s_y;
    logic [RIDX_W-1:0]     s_row_index;
    logic [SPRITE_W-1:0]   s_sprite_byte;
    logic                  s_last_row;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_collision;
    logic [ROW_BITS_W-1:0] m_row_bits;

    sprite_xor_framebuffer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_x           (s_x),
        .s_y           (s_y),
        .s_row_index   (s_row_index),
        .s_sprite_byte (s_sprite_byte),
        .s_last_row    (s_last_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_collision   (m_collision),
        .m_row_bits    (m_row_bits)
    );

    // Mirror of the block: screen contents and the sticky collision flag
    logic [ROW_BITS_W-1:0] screen_rows [HEIGHT];
    logic                  collision_sticky;

    fb_request_t request_queue[$];
    fb_result_t  due_results[$];

    int  n_queued;
    int  n_counted;
    int  n_accepted;
    int  n_results;
    int  n_collisions;
    int  n_row_reads;
    int  n_clears;
    int  n_errors;
    int  clock_count;
    bit  drain_next;
    bit  req_taken;

    // Sender burst state
    int  burst_left;
    int  gap_left;

    // Receiver stall state
    ready_style_t ready_style;
    int           style_left;
    logic [31:0]  ready_word;
    int           run_left;
    bit           run_high;

    // 12 ns period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        clock_count <= clock_count + 1;
    end

    // Queue one request; command 3 is ignored by the block and is not counted
    task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [X_W-1:0] x,
                                input logic [Y_W-1:0] y, input logic [RIDX_W-1:0] ri,
                                input logic [SPRITE_W-1:0] spr, input logic last);
        fb_request_t req;
        req.cmd         = cmd;
        req.x           = x;
        req.y           = y;
        req.row_index   = ri;
        req.sprite_byte = spr;
        req.last_row    = last;
        req.drain_first = drain_next;
        drain_next      = 1'b0;
        request_queue.push_back(req);
        n_queued++;
        if (cmd != CMD_UNUSED) n_counted++;
    endtask

    // Queue one whole sprite of up to 16 rows with random content. A broken
    // sprite either never sets last_row, so its collision carries into the
    // next sprite, or uses scrambled row offsets.
    task automatic add_sprite(input bit broken);
        int              rows;
        int              place;
        logic [X_W-1:0]  x;
        logic [Y_W-1:0]  y;
        logic [RIDX_W-1:0] ri;
        logic            last;
        bit              drop_last;
        rows  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        place = $urandom_range(0, 3);
        case (place)
            0: begin
                // crowd a small corner so sprites overlap and collide
                x = X_W'($urandom_range(0, 15));
                y = Y_W'($urandom_range(0, 7));
            end
            1: begin
                // push against the right and bottom edges
                x = X_W'($urandom_range(56, 63));
                y = Y_W'($urandom_range(20, 31));
            end
            default: begin
                x = X_W'($urandom_range(0, 63));
                y = Y_W'($urandom_range(0, 31));
            end
        endcase
        drop_last = broken && $urandom_range(0, 1);
        for (int k = 0; k < rows; k++) begin
            ri   = (broken && !drop_last) ? RIDX_W'($urandom_range(0, 15)) : RIDX_W'(k);
            last = (k == rows - 1) && !drop_last;
            push_request(CMD_DRAW, x, y, ri, SPRITE_W'($urandom_range(0, 255)), last);
        end
    endtask

    // Advance the mirror by one accepted request and queue the result it owes
    function automatic void apply_request(input fb_request_t req);
        logic [6:0]            target;
        logic [ROW_BITS_W-1:0] sprite_bits;
        fb_result_t            res;
        case (req.cmd)
            CMD_CLEAR: begin
                foreach (screen_rows[r]) screen_rows[r] = '0;
                n_clears++;
            end
            CMD_DRAW: begin
                target = 7'(req.y) + 7'(req.row_index);
                // drop rows below the bottom edge; the shift clips the right edge
                if (target < HEIGHT) begin
                    sprite_bits = ({req.sprite_byte, {(ROW_BITS_W - SPRITE_W){1'b0}}} >> req.x)
                                  & ON_SCREEN;
                    if ((screen_rows[target] & sprite_bits) != '0) collision_sticky = 1'b1;
                    screen_rows[target] ^= sprite_bits;
                end
                if (req.last_row) begin
                    res.collision = collision_sticky;
                    res.row_bits  = '0;
                    due_results.push_back(res);
                    collision_sticky = 1'b0;
                end
            end
            CMD_READ: begin
                res.collision = 1'b0;
                res.row_bits  = (req.y < HEIGHT) ? screen_rows[req.y] : '0;
                due_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Monitor: check results first so a spurious one cannot match a fresh
    // expectation, then record the request taken at this edge
    always @(posedge aclk) begin : watch_ports
        fb_request_t seen;
        fb_result_t  want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, collision %0b row_bits %h",
                             $time, m_collision, m_row_bits);
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    n_results++;
                    if (want.collision) n_collisions++;
                    if (m_collision !== want.collision) begin
                        $display("%0t: collision mismatch, expected %0b, actual %0b",
                                 $time, want.collision, m_collision);
                        n_errors++;
                    end
                    if (m_row_bits !== want.row_bits) begin
                        $display("%0t: row_bits mismatch, expected %h, actual %h",
                                 $time, want.row_bits, m_row_bits);
                        n_errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                seen.cmd         = s_command;
                seen.x           = s_x;
                seen.y           = s_y;
                seen.row_index   = s_row_index;
                seen.sprite_byte = s_sprite_byte;
                seen.last_row    = s_last_row;
                seen.drain_first = 1'b0;
                if (s_command == CMD_READ) n_row_reads++;
                apply_request(seen);
                n_accepted++;
                req_taken = 1'b1;
            end
        end
    end

    // Driver: hold a request until it is taken, then either sit out a gap
    // or present the next one. A request marked drain_first waits until
    // every outstanding result has been delivered.
    always @(negedge aclk) begin : drive_requests
        fb_request_t nxt;
        if (aresetn) begin
            if (!s_valid || req_taken) begin
                req_taken = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_queue.size() != 0 &&
                             !(request_queue[0].drain_first && due_results.size() != 0)) begin
                    nxt = request_queue.pop_front();
                    s_command     <= nxt.cmd;
                    s_x           <= nxt.x;
                    s_y           <= nxt.y;
                    s_row_index   <= nxt.row_index;
                    s_sprite_byte <= nxt.sprite_byte;
                    s_last_row    <= nxt.last_row;
                    s_valid       <= 1'b1;
                    if (burst_left <= 1) begin
                        // long bursts now and then, otherwise short ones
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switch between stall styles at random intervals
    always @(negedge aclk) begin : drive_ready
        if (aresetn) begin
            if (style_left == 0) begin
                ready_style = ready_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(50, 300);
                ready_word  = $urandom | 32'h1;
            end else begin
                style_left--;
            end
            case (ready_style)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_ROTATE: begin
                    m_ready   <= ready_word[0];
                    ready_word = {ready_word[0], ready_word[31:1]};
                end
                READY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    // long stalls with brief windows of readiness
                    if (run_left == 0) begin
                        run_high = !run_high;
                        run_left = run_high ? $urandom_range(1, 4) : $urandom_range(5, 24);
                    end else begin
                        run_left--;
                    end
                    m_ready <= run_high;
                end
            endcase
        end
    end

    // Watchdog: end a hung run
    initial begin
        wait (clock_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : run_test
        int pick;
        int next_drain;

        // Initialise every input and the mirror before the first edge
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_command        = CMD_CLEAR;
        s_x              = '0;
        s_y              = '0;
        s_row_index      = '0;
        s_sprite_byte    = '0;
        s_last_row       = 1'b0;
        m_ready          = 1'b0;
        foreach (screen_rows[r]) screen_rows[r] = '0;
        collision_sticky = 1'b0;
        clock_count      = 0;
        n_queued         = 0;
        n_counted        = 0;
        n_accepted       = 0;
        n_results        = 0;
        n_collisions     = 0;
        n_row_reads      = 0;
        n_clears         = 0;
        n_errors         = 0;
        drain_next       = 1'b0;
        req_taken        = 1'b0;
        burst_left       = 20;
        gap_left         = 0;
        ready_style      = READY_ALWAYS;
        style_left       = 40;
        ready_word       = 32'h1;
        run_left         = 0;
        run_high         = 1'b0;

        // Directed opening: blank screen, self-collision, both clipping edges,
        // clear leaving the flag alone, the ignored command and field extremes
        push_request(CMD_READ, 0, 0, 0, 0, 0);
        push_request(CMD_DRAW, 0, 0, 0, 8'hFF, 0);
        push_request(CMD_DRAW, 0, 0, 0, 8'hFF, 1);
        push_request(CMD_READ, 0, 0, 0, 0, 0);
        push_request(CMD_DRAW, 63, 31, 0, 8'hFF, 1);
        push_request(CMD_READ, 0, 31, 0, 0, 0);
        push_request(CMD_DRAW, 60, 16, 15, 8'hA5, 0);
        push_request(CMD_DRAW, 60, 17, 15, 8'hFF, 1);
        push_request(CMD_READ, 63, 31, 15, 8'hFF, 1);
        push_request(CMD_DRAW, 5, 10, 3, 8'h3C, 0);
        push_request(CMD_DRAW, 5, 10, 3, 8'h3C, 0);
        push_request(CMD_CLEAR, 63, 31, 15, 8'hFF, 1);
        push_request(CMD_READ, 0, 13, 0, 0, 0);
        push_request(CMD_DRAW, 0, 31, 15, 8'h00, 1);
        push_request(CMD_UNUSED, 63, 31, 15, 8'hFF, 1);
        push_request(CMD_DRAW, 63, 31, 15, 8'hFF, 1);
        push_request(CMD_DRAW, 32, 5, 0, 8'h80, 1);
        push_request(CMD_READ, 0, 5, 0, 0, 0);
        push_request(CMD_DRAW, 0, 0, 15, 8'h01, 1);
        push_request(CMD_READ, 0, 15, 0, 0, 0);
        push_request(CMD_READ, 0, 31, 0, 0, 0);

        // Random part: mostly well-formed sprites and reads, with clears,
        // the ignored command, stray draws and broken sprites as noise
        next_drain = 150;
        while (n_counted < RANDOM_REQUESTS) begin
            if (n_counted >= next_drain) begin
                drain_next = 1'b1;
                next_drain = n_counted + $urandom_range(200, 350);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                add_sprite(pick < 6);
            end else if (pick < 85) begin
                push_request(CMD_READ, X_W'($urandom_range(0, 63)), Y_W'($urandom_range(0, 31)),
                             RIDX_W'($urandom_range(0, 15)), SPRITE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end else if (pick < 88) begin
                push_request(CMD_CLEAR, X_W'($urandom_range(0, 63)), Y_W'($urandom_range(0, 31)),
                             RIDX_W'($urandom_range(0, 15)), SPRITE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end else if (pick < 91) begin
                push_request(CMD_UNUSED, X_W'($urandom_range(0, 63)), Y_W'($urandom_range(0, 31)),
                             RIDX_W'($urandom_range(0, 15)), SPRITE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end else begin
                push_request(CMD_DRAW, X_W'($urandom_range(0, 63)), Y_W'($urandom_range(0, 31)),
                             RIDX_W'($urandom_range(0, 15)), SPRITE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end
        end

        // Hold reset, then release it away from the sampling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: every request taken, every result delivered, then let the
        // pipeline settle so a stray late result is still caught
        wait (n_accepted == n_queued);
        wait (due_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d requests (%0d screen clears); checked %0d results,",
                 n_accepted, n_clears, n_results);
        $display("of which %0d row reads and %0d collision reports.", n_row_reads, n_collisions);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
